// ===== rtl/amrl_pkg.sv =====
// shared types and constants of the adaptive message rate limiter
package amrl_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic [31:0] NS_PER_SEC    = 32'd1000000000;
  localparam logic [63:0] NS_PER_SEC_64 = 64'd1000000000;
  localparam logic [31:0] LIMIT_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_TARGET_RATE   = 2'd0,
    REG_PAUSE_NS      = 2'd1,
    REG_INITIAL_LIMIT = 2'd2,
    REG_START_TIME_NS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              en;
    reg_idx_t          idx;
    logic [DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] target_rate;
    logic [29:0] pause_ns;
    logic [31:0] initial_limit;
    logic [63:0] start_time_ns;
  } cfg_regs_t;

  // which of the two multiply/divide passes is running
  typedef enum logic {
    PH_MEASURE = 1'b0,
    PH_ADAPT   = 1'b1
  } phase_t;

  typedef struct packed {
    logic   accept;
    logic   load_out;
    logic   mul_en;
    logic   div_start;
    logic   latch_meas;
    logic   finish;
    phase_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic need_adapt;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/amrl_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module amrl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [amrl_pkg::DIV_W-1:0] dividend,
  input  logic [amrl_pkg::DIV_W-1:0] divisor,
  output logic [amrl_pkg::DIV_W-1:0] quotient,
  output logic                      done
);
  import amrl_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= DIV_CNT_W'(DIV_W - 1);
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  // quotient is final in the cycle after done
  assign done     = busy && cnt == '0;
  assign quotient = quo;

endmodule

// ===== rtl/amrl_dp.sv =====
// datapath: configuration, limiter state, multiplier, divider and output word
module amrl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  amrl_pkg::cfg_wr_t           cfg_wr,
  output amrl_pkg::cfg_regs_t         cfg_regs,
  input  logic                        in_op,
  input  logic [63:0]                 in_now,
  input  amrl_pkg::dp_cmd_t           cmd,
  output amrl_pkg::dp_stat_t          stat,
  output logic                        out_pause,
  output logic [31:0]                 out_limit
);
  import amrl_pkg::*;

  cfg_regs_t   regs;
  logic [31:0] msg_count;
  logic [31:0] burst_limit;
  logic [63:0] window_start;
  logic        awaiting_resume;

  logic [31:0] cnt_l;
  logic [29:0] e_l;
  logic [63:0] mul_r;
  logic [63:0] meas_r;

  logic [63:0] elapsed;
  logic [31:0] cnt_inc;
  logic        event_pause;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] div_dvs;
  logic [63:0] div_q;
  logic        div_done;
  logic [63:0] q;
  logic [31:0] q_sat;

  assign elapsed = in_now - window_start;
  assign cnt_inc = (msg_count == LIMIT_MAX) ? msg_count : msg_count + 32'd1;
  assign event_pause = !in_op && !awaiting_resume && burst_limit != '0 &&
                       cnt_inc >= burst_limit;

  assign stat.need_adapt = in_op && awaiting_resume && in_now >= window_start &&
                           elapsed < NS_PER_SEC_64;
  assign stat.div_done   = div_done;

  assign mul_a   = (cmd.phase == PH_MEASURE) ? cnt_l : burst_limit;
  assign mul_b   = (cmd.phase == PH_MEASURE) ? NS_PER_SEC : regs.target_rate;
  assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
  assign div_dvs = (cmd.phase == PH_MEASURE) ? {34'd0, e_l} : meas_r;

  amrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mul_r),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // a zero measured rate leaves the product undivided
  assign q     = (meas_r == '0) ? mul_r : div_q;
  assign q_sat = (q[63:32] != '0) ? LIMIT_MAX : q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs            <= '0;
      msg_count       <= '0;
      burst_limit     <= '0;
      window_start    <= '0;
      awaiting_resume <= 1'b0;
    end else begin
      if (cfg_wr.en) begin
        unique case (cfg_wr.idx)
          REG_TARGET_RATE:   regs.target_rate <= cfg_wr.data[31:0];
          REG_PAUSE_NS:      regs.pause_ns <= cfg_wr.data[29:0];
          REG_INITIAL_LIMIT: begin
            regs.initial_limit <= cfg_wr.data[31:0];
            burst_limit        <= cfg_wr.data[31:0];
          end
          REG_START_TIME_NS: begin
            regs.start_time_ns <= cfg_wr.data;
            window_start       <= cfg_wr.data;
          end
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (!in_op) begin
          if (!awaiting_resume && burst_limit != '0) begin
            msg_count <= cnt_inc;
            if (cnt_inc >= burst_limit) begin
              awaiting_resume <= 1'b1;
            end
          end
        end else if (awaiting_resume) begin
          window_start    <= in_now;
          msg_count       <= 32'd1;
          awaiting_resume <= 1'b0;
        end
      end
      if (cmd.finish) begin
        burst_limit <= q_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt_l <= msg_count;
      // zero elapsed time counts as 1 ns
      e_l   <= (elapsed[29:0] == '0) ? 30'd1 : elapsed[29:0];
    end
    if (cmd.mul_en) begin
      mul_r <= mul_p;
    end
    if (cmd.latch_meas) begin
      meas_r <= div_q;
    end
    if (cmd.load_out) begin
      out_pause <= event_pause;
      out_limit <= burst_limit;
    end else if (cmd.finish) begin
      out_pause <= 1'b0;
      out_limit <= q_sat;
    end
  end

  assign cfg_regs = regs;

endmodule

// ===== rtl/amrl_ctrl.sv =====
// controller: input/output handshake and sequencing of the limit update
module amrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  amrl_pkg::dp_stat_t  stat,
  output amrl_pkg::dp_cmd_t   cmd
);
  import amrl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL1  = 8'b0000_0010,
    S_DIV1  = 8'b0000_0100,
    S_WAIT1 = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_DIV2  = 8'b0010_0000,
    S_WAIT2 = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   in_fire;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.phase  = PH_MEASURE;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.accept = 1'b1;
          if (stat.need_adapt) begin
            state_next = S_MUL1;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.div_done) begin
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.phase      = PH_ADAPT;
        cmd.mul_en     = 1'b1;
        cmd.latch_meas = 1'b1;
        state_next     = S_DIV2;
      end
      S_DIV2: begin
        cmd.phase     = PH_ADAPT;
        cmd.div_start = 1'b1;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.phase = PH_ADAPT;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.phase = PH_ADAPT;
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out || cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_adapt_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && stat.need_adapt |=> state == S_MUL1)
    else $error("adapting resume did not start the multiply pass");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_free |=> m_tvalid && state == S_IDLE)
    else $error("finished update did not produce an output word");

  a_div_done_waits: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_WAIT1 || state == S_WAIT2)
    else $error("divider finished outside a wait state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd.accept && !cmd.load_out)
    else $error("input taken while an update is running");
`endif

endmodule

// ===== rtl/adaptive_message_rate_limiter.sv =====
// adaptive message rate limiter: top level with configuration port
// message events and resumes that keep the limit are taken in idle; result word in the next cycle
// a resume that adapts the limit runs two 64-step divider passes, one bit per cycle,
// with a multiply before each; one word is worked on at a time, and the output register
// frees the input side; synchronous active-high reset clears configuration, limiter state,
// controller state and output valid; a zero limit keeps the block disabled
module adaptive_message_rate_limiter (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [amrl_pkg::ADDR_W-1:0] paddr,
  input  logic [amrl_pkg::DATA_W-1:0] pwdata,
  output logic [amrl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // [63:0] now_ns
  input  logic                        s_tuser,   // [0] operation
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [31:0] limit_now
  output logic                        m_tuser    // [0] pause
);
  import amrl_pkg::*;

  cfg_wr_t   cfg_wr;
  cfg_regs_t cfg_regs;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  reg_idx_t  rd_idx;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = reg_idx_t'(paddr[4:3]);
  assign cfg_wr.data = pwdata;
  assign rd_idx      = reg_idx_t'(paddr[4:3]);

  always_comb begin
    unique case (rd_idx)
      REG_TARGET_RATE:   prdata = {32'd0, cfg_regs.target_rate};
      REG_PAUSE_NS:      prdata = {34'd0, cfg_regs.pause_ns};
      REG_INITIAL_LIMIT: prdata = {32'd0, cfg_regs.initial_limit};
      REG_START_TIME_NS: prdata = cfg_regs.start_time_ns;
      default:           prdata = '0;
    endcase
  end

  amrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  amrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_regs  (cfg_regs),
    .in_op     (s_tuser),
    .in_now    (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_pause (m_tuser),
    .out_limit (m_tdata)
  );

endmodule
